// ===== rtl/core/sudc_pkg.sv =====
// Shared types, codes, constants and the CRC-8 fold function for the datagram codec.
`default_nettype none

package sudc_pkg;

    // Command codes carried with each input beat.
    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_RESP  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // Report status codes.
    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_BAD_ARG = 2'd1,
        STAT_BAD_RSP = 2'd2
    } t_status;

    // Result kinds.
    localparam logic KIND_TX     = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Datagram constants.
    localparam logic [7:0] SYNC_BYTE  = 8'h05;
    localparam logic [7:0] REPLY_ADDR = 8'hff;
    localparam logic [7:0] WRITE_FLAG = 8'h80;
    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] MAX_NODE   = 8'h03;

    // Response frame length and the saturation point of the byte counter.
    localparam logic [3:0] FRAME_LEN      = 4'd8;
    localparam logic [3:0] BYTE_COUNT_MAX = 4'd9;

    // One result beat.
    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [31:0] read_value;
        t_status     status;
    } t_result;

    // Fold one byte into a CRC-8, taking the byte LSB first.
    function automatic logic [7:0] crc_fold(input logic [7:0] crc_in,
                                            input logic [7:0] data_in);
        logic [7:0] c;
        logic [7:0] d;
        logic       fb;
        c = crc_in;
        d = data_in;
        for (int i = 0; i < 8; i++) begin
            fb = c[7] ^ d[0];
            c  = {c[6:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
            d = {1'b0, d[7:1]};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sudc_req_framer.sv =====
// Request framer: walks the bytes of a read or write datagram and folds its CRC.
`default_nettype none

module sudc_req_framer (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire logic                  i_is_write,
    input  wire logic [7:0]            i_node_address,
    input  wire logic [7:0]            i_register_address,
    input  wire logic [31:0]           i_write_value,
    output sudc_pkg::t_result          o_res
);

    localparam logic [2:0] IDX_SYNC   = 3'd0;
    localparam logic [2:0] IDX_NODE   = 3'd1;
    localparam logic [2:0] IDX_REG    = 3'd2;
    localparam logic [2:0] READ_LAST  = 3'd3;
    localparam logic [2:0] WRITE_LAST = 3'd7;

    logic [2:0] r_idx;
    logic [2:0] n_idx;
    logic [7:0] r_crc;
    logic [7:0] n_crc;
    logic       bad_arg;
    logic       at_crc;
    logic [7:0] cur_byte;

    // Argument check: node above the limit or a register with the write flag set.
    assign bad_arg = (i_node_address > sudc_pkg::MAX_NODE) ||
                     ((i_register_address & sudc_pkg::WRITE_FLAG) != 8'h00);

    assign at_crc = i_is_write ? (r_idx == WRITE_LAST) : (r_idx == READ_LAST);

    // Select the byte at the current position of the datagram.
    always_comb begin
        priority if (at_crc) begin
            cur_byte = r_crc;
        end else if (r_idx == IDX_SYNC) begin
            cur_byte = sudc_pkg::SYNC_BYTE;
        end else if (r_idx == IDX_NODE) begin
            cur_byte = i_node_address;
        end else if (r_idx == IDX_REG) begin
            cur_byte = i_is_write ? (i_register_address | sudc_pkg::WRITE_FLAG)
                                  : i_register_address;
        end else begin
            unique case (r_idx[1:0])
                2'd3:    cur_byte = i_write_value[31:24];
                2'd0:    cur_byte = i_write_value[23:16];
                2'd1:    cur_byte = i_write_value[15:8];
                default: cur_byte = i_write_value[7:0];
            endcase
        end
    end

    // Result beat for the current position.
    always_comb begin
        if (bad_arg) begin
            o_res.kind       = sudc_pkg::KIND_REPORT;
            o_res.tx_byte    = 8'h00;
            o_res.last       = 1'b1;
            o_res.read_value = 32'h0;
            o_res.status     = sudc_pkg::STAT_BAD_ARG;
        end else begin
            o_res.kind       = sudc_pkg::KIND_TX;
            o_res.tx_byte    = cur_byte;
            o_res.last       = at_crc;
            o_res.read_value = 32'h0;
            o_res.status     = sudc_pkg::STAT_OK;
        end
    end

    // Advance the position and the running CRC with each emitted beat.
    always_comb begin
        n_idx = r_idx;
        n_crc = r_crc;
        if (i_step) begin
            if (o_res.last) begin
                n_idx = IDX_SYNC;
                n_crc = 8'h00;
            end else begin
                n_idx = r_idx + 3'd1;
                n_crc = sudc_pkg::crc_fold(r_crc, cur_byte);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= IDX_SYNC;
            r_crc <= 8'h00;
        end else begin
            r_idx <= n_idx;
            r_crc <= n_crc;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sudc_rsp_deframer.sv =====
// Response deframer: absorbs reply bytes, checks the frame and decodes the value.
`default_nettype none

module sudc_rsp_deframer (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_take,
    input  wire logic [7:0]            i_rx_byte,
    input  wire logic                  i_rx_last,
    input  wire logic [7:0]            i_register_address,
    output sudc_pkg::t_result          o_res
);

    logic [7:0]  r_crc;
    logic [7:0]  n_crc;
    logic [7:0]  r_held;
    logic [3:0]  r_count;
    logic [3:0]  n_count;
    logic        r_hdr_ok;
    logic        n_hdr_ok;
    logic [7:0]  r_reply_reg;
    logic [7:0]  n_reply_reg;
    logic [31:0] r_shift;
    logic [31:0] n_shift;
    logic        frame_ok;

    // Fold the previous byte, check header bytes and collect register and data.
    always_comb begin
        n_crc       = (r_count != 4'd0) ? sudc_pkg::crc_fold(r_crc, r_held) : r_crc;
        n_hdr_ok    = r_hdr_ok &
                      !((r_count == 4'd0) && (i_rx_byte != sudc_pkg::SYNC_BYTE)) &
                      !((r_count == 4'd1) && (i_rx_byte != sudc_pkg::REPLY_ADDR));
        n_reply_reg = (r_count == 4'd2) ? i_rx_byte : r_reply_reg;
        n_shift     = ((r_count >= 4'd3) && (r_count <= 4'd6)) ?
                      {r_shift[23:0], i_rx_byte} : r_shift;
        n_count     = (r_count < sudc_pkg::BYTE_COUNT_MAX) ? r_count + 4'd1 : r_count;
    end

    // The last byte is the CRC over everything before it.
    assign frame_ok = (n_count == sudc_pkg::FRAME_LEN) && n_hdr_ok &&
                      (n_reply_reg == i_register_address) && (n_crc == i_rx_byte);

    // Report for a final byte.
    always_comb begin
        o_res.kind    = sudc_pkg::KIND_REPORT;
        o_res.tx_byte = 8'h00;
        o_res.last    = 1'b1;
        if ((i_register_address & sudc_pkg::WRITE_FLAG) != 8'h00) begin
            o_res.read_value = 32'h0;
            o_res.status     = sudc_pkg::STAT_BAD_ARG;
        end else if (frame_ok) begin
            o_res.read_value = n_shift;
            o_res.status     = sudc_pkg::STAT_OK;
        end else begin
            o_res.read_value = 32'h0;
            o_res.status     = sudc_pkg::STAT_BAD_RSP;
        end
    end

    // Frame state; a final byte returns it to its idle values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_rx_last)) begin
            r_crc       <= 8'h00;
            r_held      <= 8'h00;
            r_count     <= 4'd0;
            r_hdr_ok    <= 1'b1;
            r_reply_reg <= 8'h00;
            r_shift     <= 32'h0;
        end else if (i_take) begin
            r_crc       <= n_crc;
            r_held      <= i_rx_byte;
            r_count     <= n_count;
            r_hdr_ok    <= n_hdr_ok;
            r_reply_reg <= n_reply_reg;
            r_shift     <= n_shift;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/stepper_uart_datagram_codec.sv =====
// Top level of the single-wire UART datagram codec: input register, framer, deframer, output register.
`default_nettype none

// Each input beat enters an input register and its results leave through an output
// register; a beat that gives one report, or none, is taken every cycle while the
// output is not stalled. A read request gives four transmit beats and a write request
// eight; the output register moves one beat per cycle unless i_stall holds it, and a
// request holds the input register while the framer steps through its bytes and folds
// the CRC one byte at a time. Response bytes that are not final give no result and
// are absorbed even under an output stall. The command code 3 is dropped without a result.
module stepper_uart_datagram_codec (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [7:0]  i_node_address,
    input  wire logic [7:0]  i_register_address,
    input  wire logic [31:0] i_write_value,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_rx_last,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_kind,
    output logic [7:0]       o_tx_byte,
    output logic             o_last,
    output logic [31:0]      o_read_value,
    output logic [1:0]       o_status
);

    logic              r_in_valid;
    sudc_pkg::t_cmd    r_cmd;
    logic [7:0]        r_node;
    logic [7:0]        r_reg;
    logic [31:0]       r_value;
    logic [7:0]        r_rx_byte;
    logic              r_rx_last;

    logic              r_out_valid;
    sudc_pkg::t_result r_out;

    logic              head_req;
    logic              head_rsp;
    logic              has_result;
    logic              out_free;
    logic              pop;
    logic              req_step;
    logic              rsp_take;
    sudc_pkg::t_result req_res;
    sudc_pkg::t_result rsp_res;
    sudc_pkg::t_result sel_res;

    // Decode the held beat.
    assign head_req   = r_in_valid && ((r_cmd == sudc_pkg::CMD_READ) ||
                                       (r_cmd == sudc_pkg::CMD_WRITE));
    assign head_rsp   = r_in_valid && (r_cmd == sudc_pkg::CMD_RESP);
    assign has_result = head_req || (head_rsp && r_rx_last);
    assign out_free   = !r_out_valid || !i_stall;

    // The held beat leaves once its last result is loaded, or at once if it has none.
    assign pop      = r_in_valid && (has_result ? (out_free && sel_res.last) : 1'b1);
    assign req_step = head_req && out_free;
    assign rsp_take = head_rsp && (!r_rx_last || out_free);
    assign o_stall  = r_in_valid && !pop;

    assign sel_res = head_req ? req_res : rsp_res;

    sudc_req_framer u_framer (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (req_step),
        .i_is_write         (r_cmd == sudc_pkg::CMD_WRITE),
        .i_node_address     (r_node),
        .i_register_address (r_reg),
        .i_write_value      (r_value),
        .o_res              (req_res)
    );

    sudc_rsp_deframer u_deframer (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_take             (rsp_take),
        .i_rx_byte          (r_rx_byte),
        .i_rx_last          (r_rx_last),
        .i_register_address (r_reg),
        .o_res              (rsp_res)
    );

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_cmd     <= sudc_pkg::t_cmd'(i_cmd);
            r_node    <= i_node_address;
            r_reg     <= i_register_address;
            r_value   <= i_write_value;
            r_rx_byte <= i_rx_byte;
            r_rx_last <= i_rx_last;
        end
    end

    // Output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= has_result;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (out_free && has_result) begin
            r_out <= sel_res;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_kind       = r_out.kind;
    assign o_tx_byte    = r_out.tx_byte;
    assign o_last       = r_out.last;
    assign o_read_value = r_out.read_value;
    assign o_status     = r_out.status;

endmodule

`default_nettype wire
